// ===== sv/bbcw_pkg.sv =====
// ----------------------------------------------------------------------------
// bbcw_pkg
// shared types and constants of the clamped-window box blur
// ----------------------------------------------------------------------------
package bbcw_pkg;

   localparam int CHAN_W      = 8;
   localparam int COORD_W     = 9;
   localparam int DIM_W       = 13;
   localparam int FRAME_W     = 9;
   localparam int RAD_W       = 3;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 9;

   localparam int MAX_ROWS_DEF   = 256;
   localparam int MAX_COLS_DEF   = 256;
   localparam int MAX_RADIUS_DEF = 7;

   localparam logic [FRAME_W-1:0] FRAME_ROWS_RST = 9'd256;
   localparam logic [FRAME_W-1:0] FRAME_COLS_RST = 9'd256;
   localparam logic [RAD_W-1:0]   RADIUS_RST     = 3'd1;

   localparam logic [CSR_IDX_W-1:0] REG_FRAME_ROWS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_COLS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_RADIUS     = 2'd2;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef struct packed {
      logic              operation;
      logic [7:0]        pixel_row;
      logic [7:0]        pixel_col;
      logic [CHAN_W-1:0] chan_a_in;
      logic [CHAN_W-1:0] chan_b_in;
      logic [CHAN_W-1:0] chan_c_in;
   } req_type;

   typedef struct packed {
      logic [CHAN_W-1:0] chan_a_avg;
      logic [CHAN_W-1:0] chan_b_avg;
      logic [CHAN_W-1:0] chan_c_avg;
   } rsp_type;

endpackage

// ===== sv/box_blur_clamped_window.sv =====
// ----------------------------------------------------------------------------
// box_blur_clamped_window
// rgb frame store with clipped square-window mean queries
// ----------------------------------------------------------------------------
// usage:
//   req channel: an item transfers when start is high and busy is low.
//   a write item stores one pixel and busy stays low.
//   writes and queries outside the configured frame are dropped, no result.
//   a query walks the clipped window one pixel per cycle through the frame
//   ram read port, then one shared restoring divider turns the three channel
//   sums into means, 8 steps per channel plus a load step.
//   during a query busy is high until the result cycle, so the next item can
//   transfer at that edge.
//   rsp channel: rsp_valid is high for exactly one cycle with rsp_payload;
//   the receiver cannot stall it.
//   csr channel: csr_ready is always high; write only while busy is low.
//   reset: frame 256 x 256, radius 1; frame ram contents are undefined.
// ----------------------------------------------------------------------------
module box_blur_clamped_window #(
   parameter int MAX_ROWS   = bbcw_pkg::MAX_ROWS_DEF,
   parameter int MAX_COLS   = bbcw_pkg::MAX_COLS_DEF,
   parameter int MAX_RADIUS = bbcw_pkg::MAX_RADIUS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  bbcw_pkg::req_type              req_payload,
   output logic                           rsp_valid,
   output bbcw_pkg::rsp_type              rsp_payload,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [bbcw_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bbcw_pkg::CSR_DATA_W-1:0] csr_data
);

   localparam int DEPTH   = MAX_ROWS * MAX_COLS;
   localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_MAX = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
   localparam int CNT_W   = $clog2(CNT_MAX + 1);
   localparam int SUM_W   = $clog2(CNT_MAX * 255 + 1);
   localparam int CHAN_W  = bbcw_pkg::CHAN_W;
   localparam int COORD_W = bbcw_pkg::COORD_W;
   localparam int DIM_W   = bbcw_pkg::DIM_W;
   localparam int RAD_W   = bbcw_pkg::RAD_W;
   localparam int FRAME_W = bbcw_pkg::FRAME_W;
   localparam int STEP_W  = $clog2(CHAN_W);
   localparam int PIX_W   = 3 * CHAN_W;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SCAN  = 3'd1;
   localparam logic [2:0] S_DRAIN = 3'd2;
   localparam logic [2:0] S_DLOAD = 3'd3;
   localparam logic [2:0] S_DIV   = 3'd4;

   localparam logic [1:0] CH_A = 2'd0;
   localparam logic [1:0] CH_B = 2'd1;
   localparam logic [1:0] CH_C = 2'd2;

   logic [2:0]         state_ff, state_in;
   logic [FRAME_W-1:0] rows_ff, cols_ff;
   logic [RAD_W-1:0]   radius_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rd_pend_ff, rd_pend_in;
   logic [COORD_W-1:0] win_r0_ff, win_r0_in, win_r1_ff, win_r1_in;
   logic [COORD_W-1:0] win_c0_ff, win_c0_in, win_c1_ff, win_c1_in;
   logic [COORD_W-1:0] cur_r_ff, cur_r_in, cur_c_ff, cur_c_in;
   logic [SUM_W-1:0]   sum_a_ff, sum_a_in, sum_b_ff, sum_b_in, sum_c_ff, sum_c_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [CNT_W-1:0]   div_rem_ff, div_rem_in;
   logic [CHAN_W-1:0]  div_quo_ff, div_quo_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [1:0]         ch_ff, ch_in;
   bbcw_pkg::rsp_type  rsp_data_ff, rsp_data_in;

   logic [DIM_W-1:0]   rows_used, cols_used, req_r, req_c, rad_ext;
   logic [RAD_W-1:0]   rad_used;
   logic               accept, in_frame;
   logic               wr_en, rd_en;
   logic [ADDR_W-1:0]  wr_addr, rd_addr;
   logic [PIX_W-1:0]   wr_data, rd_data;
   logic [SUM_W-1:0]   sel_sum;
   logic [CNT_W:0]     shifted, trial;
   logic               borrow;
   logic [CHAN_W-1:0]  quo_next;
   logic [CNT_W-1:0]   span_r, span_c;

   assign busy      = (state_ff != S_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   assign rows_used = (DIM_W'(rows_ff) > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : DIM_W'(rows_ff);
   assign cols_used = (DIM_W'(cols_ff) > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) : DIM_W'(cols_ff);
   assign rad_used  = (radius_ff > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : radius_ff;
   assign rad_ext   = DIM_W'(rad_used);
   assign req_r     = DIM_W'(req_payload.pixel_row);
   assign req_c     = DIM_W'(req_payload.pixel_col);
   assign in_frame  = (req_r < rows_used) && (req_c < cols_used);

   assign wr_en   = accept && in_frame && (req_payload.operation == bbcw_pkg::OP_WRITE);
   assign wr_addr = ADDR_W'(32'(req_payload.pixel_row) * MAX_COLS + 32'(req_payload.pixel_col));
   assign wr_data = {req_payload.chan_a_in, req_payload.chan_b_in, req_payload.chan_c_in};
   assign rd_en   = (state_ff == S_SCAN);
   assign rd_addr = ADDR_W'(32'(cur_r_ff) * MAX_COLS + 32'(cur_c_ff));

   bbcw_ram #(
      .WIDTH (PIX_W),
      .DEPTH (DEPTH)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // window pixel count
   assign span_r = CNT_W'(win_r1_ff - win_r0_ff + COORD_W'(1));
   assign span_c = CNT_W'(win_c1_ff - win_c0_ff + COORD_W'(1));
   assign cnt_in = span_r * span_c;

   // shared restoring divider step
   always_comb begin
      case (ch_ff)
         CH_A:    sel_sum = sum_a_ff;
         CH_B:    sel_sum = sum_b_ff;
         default: sel_sum = sum_c_ff;
      endcase
      shifted  = {div_rem_ff, div_quo_ff[CHAN_W-1]};
      trial    = shifted - {1'b0, cnt_ff};
      borrow   = trial[CNT_W];
      quo_next = {div_quo_ff[CHAN_W-2:0], ~borrow};
   end

   always_comb begin
      state_in    = state_ff;
      rsp_valid_in = 1'b0;
      rd_pend_in  = 1'b0;
      win_r0_in   = win_r0_ff;
      win_r1_in   = win_r1_ff;
      win_c0_in   = win_c0_ff;
      win_c1_in   = win_c1_ff;
      cur_r_in    = cur_r_ff;
      cur_c_in    = cur_c_ff;
      sum_a_in    = sum_a_ff;
      sum_b_in    = sum_b_ff;
      sum_c_in    = sum_c_ff;
      div_rem_in  = div_rem_ff;
      div_quo_in  = div_quo_ff;
      step_in     = step_ff;
      ch_in       = ch_ff;
      rsp_data_in = rsp_data_ff;

      if (rd_pend_ff) begin
         sum_a_in = sum_a_ff + SUM_W'(rd_data[3*CHAN_W-1:2*CHAN_W]);
         sum_b_in = sum_b_ff + SUM_W'(rd_data[2*CHAN_W-1:CHAN_W]);
         sum_c_in = sum_c_ff + SUM_W'(rd_data[CHAN_W-1:0]);
      end

      case (state_ff)
         S_IDLE: begin
            if (accept && in_frame && (req_payload.operation == bbcw_pkg::OP_QUERY)) begin
               win_r0_in = (req_r >= rad_ext) ? COORD_W'(req_r - rad_ext) : '0;
               win_c0_in = (req_c >= rad_ext) ? COORD_W'(req_c - rad_ext) : '0;
               win_r1_in = (req_r + rad_ext < rows_used) ? COORD_W'(req_r + rad_ext)
                                                         : COORD_W'(rows_used - DIM_W'(1));
               win_c1_in = (req_c + rad_ext < cols_used) ? COORD_W'(req_c + rad_ext)
                                                         : COORD_W'(cols_used - DIM_W'(1));
               cur_r_in  = (req_r >= rad_ext) ? COORD_W'(req_r - rad_ext) : '0;
               cur_c_in  = (req_c >= rad_ext) ? COORD_W'(req_c - rad_ext) : '0;
               sum_a_in  = '0;
               sum_b_in  = '0;
               sum_c_in  = '0;
               state_in  = S_SCAN;
            end
         end
         S_SCAN: begin
            rd_pend_in = 1'b1;
            if (cur_c_ff == win_c1_ff) begin
               cur_c_in = win_c0_ff;
               if (cur_r_ff == win_r1_ff) begin
                  state_in = S_DRAIN;
               end else begin
                  cur_r_in = cur_r_ff + COORD_W'(1);
               end
            end else begin
               cur_c_in = cur_c_ff + COORD_W'(1);
            end
         end
         S_DRAIN: begin
            ch_in    = CH_A;
            state_in = S_DLOAD;
         end
         S_DLOAD: begin
            div_rem_in = CNT_W'(sel_sum >> CHAN_W);
            div_quo_in = sel_sum[CHAN_W-1:0];
            step_in    = '0;
            state_in   = S_DIV;
         end
         S_DIV: begin
            div_rem_in = borrow ? shifted[CNT_W-1:0] : trial[CNT_W-1:0];
            div_quo_in = quo_next;
            step_in    = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(CHAN_W - 1)) begin
               case (ch_ff)
                  CH_A:    rsp_data_in.chan_a_avg = quo_next;
                  CH_B:    rsp_data_in.chan_b_avg = quo_next;
                  default: rsp_data_in.chan_c_avg = quo_next;
               endcase
               if (ch_ff == CH_C) begin
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
               end else begin
                  ch_in    = ch_ff + 2'd1;
                  state_in = S_DLOAD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         rd_pend_ff   <= 1'b0;
         rows_ff      <= bbcw_pkg::FRAME_ROWS_RST;
         cols_ff      <= bbcw_pkg::FRAME_COLS_RST;
         radius_ff    <= bbcw_pkg::RADIUS_RST;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_pend_ff   <= rd_pend_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               bbcw_pkg::REG_FRAME_ROWS: rows_ff   <= csr_data[FRAME_W-1:0];
               bbcw_pkg::REG_FRAME_COLS: cols_ff   <= csr_data[FRAME_W-1:0];
               bbcw_pkg::REG_RADIUS:     radius_ff <= csr_data[RAD_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      win_r0_ff   <= win_r0_in;
      win_r1_ff   <= win_r1_in;
      win_c0_ff   <= win_c0_in;
      win_c1_ff   <= win_c1_in;
      cur_r_ff    <= cur_r_in;
      cur_c_ff    <= cur_c_in;
      sum_a_ff    <= sum_a_in;
      sum_b_ff    <= sum_b_in;
      sum_c_ff    <= sum_c_in;
      cnt_ff      <= cnt_in;
      div_rem_ff  <= div_rem_in;
      div_quo_ff  <= div_quo_in;
      step_ff     <= step_in;
      ch_ff       <= ch_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// ===== sv/bbcw_ram.sv =====
// ----------------------------------------------------------------------------
// bbcw_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module bbcw_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 65536,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sim/box_blur_clamped_window_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_blur_clamped_window_check
// Watches the request, result and register channels of the box blur. Keeps
// its own copy of the frame and the frame settings, works out the three
// window means for every accepted query inside the frame, and compares each
// result with the oldest waiting mean. Mismatches and unexpected results are
// counted and handed to the testbench top.
// ----------------------------------------------------------------------------
module box_blur_clamped_window_check (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic                            busy,
   input  bbcw_pkg::req_type               req_payload,
   input  logic                            rsp_valid,
   input  bbcw_pkg::rsp_type               rsp_payload,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [bbcw_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bbcw_pkg::CSR_DATA_W-1:0] csr_data,
   output int                              fail_count,
   output int                              pending_count,
   output int                              result_count
);
   import bbcw_pkg::*;

   localparam int STORE_COLS = MAX_COLS_DEF;

   logic [3*CHAN_W-1:0] pixel_mem [0:MAX_ROWS_DEF*MAX_COLS_DEF-1];
   logic [FRAME_W-1:0]  rows_cfg = FRAME_ROWS_RST;
   logic [FRAME_W-1:0]  cols_cfg = FRAME_COLS_RST;
   logic [RAD_W-1:0]    rad_cfg = RADIUS_RST;
   rsp_type             blur_expected [$];
   int                  mismatches = 0;
   int                  checked = 0;

   initial begin
      fail_count = 0;
      pending_count = 0;
      result_count = 0;
   end

   function automatic int rows_in_use();
      return (rows_cfg > MAX_ROWS_DEF) ? MAX_ROWS_DEF : int'(rows_cfg);
   endfunction

   function automatic int cols_in_use();
      return (cols_cfg > MAX_COLS_DEF) ? MAX_COLS_DEF : int'(cols_cfg);
   endfunction

   function automatic rsp_type predict_blur(input int r, input int c);
      int nr, nc, rad, r0, r1, c0, c1, area, sum_a, sum_b, sum_c;
      logic [3*CHAN_W-1:0] px;
      rsp_type mean;
      nr = rows_in_use();
      nc = cols_in_use();
      rad = (rad_cfg > MAX_RADIUS_DEF) ? MAX_RADIUS_DEF : int'(rad_cfg);
      r0 = (r >= rad) ? r - rad : 0;
      c0 = (c >= rad) ? c - rad : 0;
      r1 = (r + rad < nr) ? r + rad : nr - 1;
      c1 = (c + rad < nc) ? c + rad : nc - 1;
      sum_a = 0;
      sum_b = 0;
      sum_c = 0;
      for (int i = r0; i <= r1; i++) begin
         for (int j = c0; j <= c1; j++) begin
            px = pixel_mem[i*STORE_COLS + j];
            sum_a += px[3*CHAN_W-1:2*CHAN_W];
            sum_b += px[2*CHAN_W-1:CHAN_W];
            sum_c += px[CHAN_W-1:0];
         end
      end
      area = (r1 - r0 + 1) * (c1 - c0 + 1);
      mean.chan_a_avg = CHAN_W'(sum_a / area);
      mean.chan_b_avg = CHAN_W'(sum_b / area);
      mean.chan_c_avg = CHAN_W'(sum_c / area);
      return mean;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      int r, c;
      if (reset) begin
         rows_cfg = FRAME_ROWS_RST;
         cols_cfg = FRAME_COLS_RST;
         rad_cfg = RADIUS_RST;
         blur_expected.delete();
      end else begin
         if (rsp_valid) begin
            if (blur_expected.size() == 0) begin
               if (mismatches < 10)
                  $display("%0t: result %h with no query outstanding", $realtime,
                     rsp_payload);
               mismatches++;
            end else begin
               want = blur_expected.pop_front();
               checked++;
               if (rsp_payload.chan_a_avg !== want.chan_a_avg
                   || rsp_payload.chan_b_avg !== want.chan_b_avg
                   || rsp_payload.chan_c_avg !== want.chan_c_avg) begin
                  if (mismatches < 10)
                     $display("%0t: mean mismatch, expected a %h b %h c %h, got a %h b %h c %h",
                        $realtime, want.chan_a_avg, want.chan_b_avg, want.chan_c_avg,
                        rsp_payload.chan_a_avg, rsp_payload.chan_b_avg,
                        rsp_payload.chan_c_avg);
                  mismatches++;
               end
            end
         end
         if (start && !busy) begin
            r = req_payload.pixel_row;
            c = req_payload.pixel_col;
            if (r < rows_in_use() && c < cols_in_use()) begin
               if (req_payload.operation == OP_WRITE)
                  pixel_mem[r*STORE_COLS + c] = {req_payload.chan_a_in,
                     req_payload.chan_b_in, req_payload.chan_c_in};
               else
                  blur_expected.push_back(predict_blur(r, c));
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_FRAME_ROWS: rows_cfg = csr_data[FRAME_W-1:0];
               REG_FRAME_COLS: cols_cfg = csr_data[FRAME_W-1:0];
               REG_RADIUS:     rad_cfg = csr_data[RAD_W-1:0];
               default: ;
            endcase
         end
      end
      fail_count <= mismatches;
      pending_count <= blur_expected.size();
      result_count <= checked;
   end

endmodule

// ===== sim/box_blur_clamped_window_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_blur_clamped_window_test
// Drives the box blur with pixel writes and window queries over a series of
// frame sizes and radii, from the extremes down to small random frames.
// Each phase fills a patch of the frame before querying inside it, so no
// window ever covers an unwritten pixel, and mixes in rewrites and items
// outside the frame. Gaps before requests vary from phase to phase. The
// checker beside the block predicts and compares; this module gives the
// verdict.
// ----------------------------------------------------------------------------
module box_blur_clamped_window_test;
   import bbcw_pkg::*;

   localparam int DRAIN_CYCLES = 260;
   localparam int STALL_LIMIT  = 4000;
   localparam int ITEM_GOAL    = 1550;
   localparam int STORE_COLS   = MAX_COLS_DEF;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   req_type               req_payload = '0;
   logic                  rsp_valid;
   rsp_type               rsp_payload;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   int fail_count;
   int pending_count;
   int result_count;
   int idle_pct = 0;
   int pixel_items = 0;
   int settings_seen = 0;
   int stall_cycles = 0;
   int rows_now = 256;
   int cols_now = 256;
   int rad_now = 1;
   bit written [0:MAX_ROWS_DEF*MAX_COLS_DEF-1];

   box_blur_clamped_window DUT (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   box_blur_clamped_window_check blur_check (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_payload   (req_payload),
      .rsp_valid     (rsp_valid),
      .rsp_payload   (rsp_payload),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .result_count  (result_count)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles == STALL_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic send_item(input req_type item);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (busy);
      if (item.pixel_row < rows_now && item.pixel_col < cols_now)
         pixel_items++;
   endtask

   task automatic put_pixel(input int r, input int c, input logic [23:0] rgb);
      req_type item;
      item.operation = OP_WRITE;
      item.pixel_row = 8'(r);
      item.pixel_col = 8'(c);
      {item.chan_a_in, item.chan_b_in, item.chan_c_in} = rgb;
      send_item(item);
      if (r < rows_now && c < cols_now)
         written[r*STORE_COLS + c] = 1'b1;
   endtask

   task automatic ask_pixel(input int r, input int c);
      req_type item;
      item.operation = OP_QUERY;
      item.pixel_row = 8'(r);
      item.pixel_col = 8'(c);
      {item.chan_a_in, item.chan_b_in, item.chan_c_in} = 24'($urandom);
      send_item(item);
   endtask

   // true when every pixel of the clipped window has been loaded
   function automatic bit window_ready(input int r, input int c);
      int r0, r1, c0, c1;
      r0 = (r >= rad_now) ? r - rad_now : 0;
      c0 = (c >= rad_now) ? c - rad_now : 0;
      r1 = (r + rad_now < rows_now) ? r + rad_now : rows_now - 1;
      c1 = (c + rad_now < cols_now) ? c + rad_now : cols_now - 1;
      for (int i = r0; i <= r1; i++)
         for (int j = c0; j <= c1; j++)
            if (!written[i*STORE_COLS + j])
               return 1'b0;
      return 1'b1;
   endfunction

   function automatic int pick_dim();
      case ($urandom_range(0, 9))
         0: return 1;
         1: return 256;
         2, 3: return $urandom_range(2, 8);
         default: return $urandom_range(9, 40);
      endcase
   endfunction

   // let outstanding queries finish and the block settle
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input int value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value[CSR_DATA_W-1:0];
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic set_frame(input int rows, input int cols, input int rad);
      drain();
      csr_write(REG_FRAME_ROWS, rows);
      csr_write(REG_FRAME_COLS, cols);
      csr_write(REG_RADIUS, rad);
      csr_valid <= 1'b0;
      rows_now = rows;
      cols_now = cols;
      rad_now = rad;
      settings_seen++;
   endtask

   task automatic run_random_phase();
      int rows, cols, rad, ph, pw, pr0, pc0, pick, r, c;
      bit found;
      rows = pick_dim();
      cols = pick_dim();
      rad = $urandom_range(1, MAX_RADIUS_DEF);
      set_frame(rows, cols, rad);
      case (settings_seen % 3)
         0: idle_pct = 0;
         1: idle_pct = 83;
         default: idle_pct = 15;
      endcase
      ph = 2*rad + 1 + $urandom_range(0, 2);
      pw = 2*rad + 1 + $urandom_range(0, 2);
      if (ph > rows) ph = rows;
      if (pw > cols) pw = cols;
      pr0 = $urandom_range(0, rows - ph);
      pc0 = $urandom_range(0, cols - pw);
      for (int i = pr0; i < pr0 + ph; i++)
         for (int j = pc0; j < pc0 + pw; j++)
            if (!written[i*STORE_COLS + j])
               put_pixel(i, j, 24'($urandom));
      repeat ($urandom_range(40, 90)) begin
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            found = 1'b0;
            for (int k = 0; k < 6 && !found; k++) begin
               r = pr0 + $urandom_range(0, ph - 1);
               c = pc0 + $urandom_range(0, pw - 1);
               found = window_ready(r, c);
            end
            if (!found) begin
               r = pr0 + ((ph > 2*rad) ? rad : 0);
               c = pc0 + ((pw > 2*rad) ? rad : 0);
            end
            ask_pixel(r, c);
         end else if (pick < 85) begin
            put_pixel(pr0 + $urandom_range(0, ph - 1), pc0 + $urandom_range(0, pw - 1),
               24'($urandom));
         end else if (pick < 92) begin
            put_pixel($urandom_range(0, rows - 1), $urandom_range(0, cols - 1),
               24'($urandom));
         end else begin
            r = $urandom_range(0, 255);
            c = $urandom_range(0, 255);
            if ((r >= rows || c >= cols || window_ready(r, c)) && $urandom_range(0, 1))
               ask_pixel(r, c);
            else
               put_pixel(r, c, 24'($urandom));
         end
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // full-size frame, corners with extreme channel values
      set_frame(256, 256, 1);
      put_pixel(0, 0, 24'hffffff);
      put_pixel(0, 1, 24'h000000);
      put_pixel(1, 0, 24'hff00ff);
      put_pixel(1, 1, 24'h00ff01);
      ask_pixel(0, 0);
      put_pixel(254, 254, 24'hffffff);
      put_pixel(254, 255, 24'hffffff);
      put_pixel(255, 254, 24'hfffffe);
      put_pixel(255, 255, 24'h80ff00);
      ask_pixel(255, 255);

      // single-pixel frame with the widest window, plus items outside it
      set_frame(1, 1, MAX_RADIUS_DEF);
      put_pixel(0, 0, 24'hfe01ff);
      ask_pixel(0, 0);
      put_pixel(0, 200, 24'h123456);
      ask_pixel(255, 0);
      ask_pixel(0, 255);

      while (pixel_items < ITEM_GOAL)
         run_random_phase();
      drain();

      $display("%0d in-frame pixel items over %0d frame settings, %0d window means checked",
         pixel_items, settings_seen, result_count);
      if (fail_count == 0 && pending_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

// ===== files.f =====
sv/bbcw_pkg.sv
sv/bbcw_ram.sv
sv/box_blur_clamped_window.sv
sim/box_blur_clamped_window_check.sv
sim/box_blur_clamped_window_test.sv
